// ===== rtl/vpa_pkg.sv =====
// Shared types, constants and codes for the variable partition allocator.
// No dependencies; every other file imports this package.
package vpa_pkg;

    // Table geometry and address range
    localparam int MAX_PARTS = 32;
    localparam int ADDR_BITS = 16;
    localparam int IDX_W     = $clog2(MAX_PARTS);
    localparam int CNT_W     = $clog2(MAX_PARTS + 1);
    localparam int SIZE_W    = 16;
    localparam int END_W     = ADDR_BITS + 1;
    localparam int SUM_W     = ADDR_BITS + 2;
    localparam int GAP_W     = 8;
    localparam int POL_W     = 2;
    localparam int OP_W      = 2;
    localparam int STS_W     = 3;
    localparam int PIDX_W    = 5;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int SEL_W     = 3;

    localparam logic [SUM_W-1:0] ADDR_LIMIT = SUM_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [CNT_W-1:0] CNT_MAX    = CNT_W'(MAX_PARTS);

    // Operation codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd2;

    // Result status codes
    localparam logic [STS_W-1:0] STS_EXACT    = 3'd0;
    localparam logic [STS_W-1:0] STS_SPLIT    = 3'd1;
    localparam logic [STS_W-1:0] STS_APPENDED = 3'd2;
    localparam logic [STS_W-1:0] STS_NOROOM   = 3'd3;
    localparam logic [STS_W-1:0] STS_FREED    = 3'd4;
    localparam logic [STS_W-1:0] STS_BADIDX   = 3'd5;
    localparam logic [STS_W-1:0] STS_LOADED   = 3'd6;

    // Fit policies
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_NEXT  = 2'd1;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd2;
    localparam logic [POL_W-1:0] POL_WORST = 2'd3;

    // Register index (word address bit)
    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_APPEND_GAP = 1'b1;

    // Table read port selects
    localparam logic [SEL_W-1:0] RD_SCAN   = 3'd0;
    localparam logic [SEL_W-1:0] RD_FOUND  = 3'd1;
    localparam logic [SEL_W-1:0] RD_LAST   = 3'd2;
    localparam logic [SEL_W-1:0] RD_FREE   = 3'd3;
    localparam logic [SEL_W-1:0] RD_ZERO   = 3'd4;
    localparam logic [SEL_W-1:0] RD_MNEXT  = 3'd5;
    localparam logic [SEL_W-1:0] RD_TARGET = 3'd6;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] req_size;
        logic [15:0] load_start;
        logic        load_used;
        logic [4:0]  free_index;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  part_index;
        logic [15:0] start_addr;
        logic [15:0] end_addr;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_W-1:0]    size;
        logic                 used;
    } entry_t;

    typedef struct packed {
        logic             latch;
        logic [SEL_W-1:0] rd_sel;
        logic             scan_init;
        logic             scan_step;
        logic             fit;
        logic             append;
        logic             load;
        logic             reject;
        logic             badidx;
        logic             free_clr;
        logic             merge_init;
        logic             merge_step;
        logic             free_rpt;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            size_zero;
        logic            idx_bad;
        logic            count_zero;
        logic            scan_last;
        logic            found;
        logic            merge_done;
    } stat_t;

endpackage

// ===== rtl/variable_partition_allocator.sv =====
// Variable partition allocator, top level: configuration registers over APB,
// controller and datapath instances. Depends on vpa_pkg, vpa_ctrl, vpa_datapath.
//
// Usage: req carries one operation (allocate, free, load) per beat, taken
// when req_valid is high and req_stall low. Each beat yields one rsp beat,
// except the unused operation code, which is dropped without a result.
// rsp_valid stays high with a stable payload while rsp_stall is high.
// Steps: allocate scans the entries (first and next fit stop at the first
// hit), then fits the found block or, with no hit, appends; free clears the
// entry, then walks the table merging free neighbours that touch, and
// reports; load checks and writes at the table end. The single table read
// port is walked one entry per cycle. One item is in flight at a time; the
// next is taken once the result sits in the output register, so a stalled
// receiver blocks only the next result, not the next accept.
// Configuration: fit_policy at byte address 0, append_gap at 4; write only
// while idle. Reset empties the table, points the rover at entry 0 and
// clears both registers.
module variable_partition_allocator
    import vpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [POL_W-1:0] fit_policy_reg;
    logic [GAP_W-1:0] append_gap_reg;
    logic             cfg_wr;
    cmd_t             cmd;
    stat_t            stat;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= POL_FIRST;
            append_gap_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_FIT_POLICY)
            begin
                fit_policy_reg <= pwdata[POL_W-1:0];
            end
            else
            begin
                append_gap_reg <= pwdata[GAP_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_APPEND_GAP) ? APB_DW'(append_gap_reg) :
                                                   APB_DW'(fit_policy_reg);

    vpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    vpa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cmd        (cmd),
        .fit_policy (fit_policy_reg),
        .append_gap (append_gap_reg),
        .stat       (stat),
        .rsp        (rsp)
    );

endmodule

// ===== rtl/vpa_datapath.sv =====
// Datapath of the partition allocator: partition table, search, split,
// append, merge and result registers. Depends on vpa_pkg.
module vpa_datapath
    import vpa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  req_t             req,
    input  cmd_t             cmd,
    input  logic [POL_W-1:0] fit_policy,
    input  logic [GAP_W-1:0] append_gap,
    output stat_t            stat,
    output rsp_t             rsp
);

    entry_t             ent_reg  [MAX_PARTS];
    entry_t             ent_next [MAX_PARTS];
    req_t               req_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   rover_reg, rover_next;
    logic               found_reg, found_next;
    logic [IDX_W-1:0]   found_idx_reg;
    logic [SIZE_W-1:0]  best_size_reg;
    logic [IDX_W-1:0]   scan_pos_reg;
    logic [CNT_W-1:0]   scan_cnt_reg;
    logic [IDX_W-1:0]   mi_reg;
    entry_t             prev_reg;
    logic [IDX_W-1:0]   target_reg;
    rsp_t               res_reg, res_next;
    logic               res_load;
    rsp_t               rsp_reg;

    logic [IDX_W-1:0]   rd_idx;
    entry_t             rd;
    logic [END_W-1:0]   rd_end;
    logic [CNT_W-1:0]   mi_p1;
    logic [CNT_W-1:0]   pos_p1;
    logic               hit, better, full;
    logic               exact;
    logic [SIZE_W-1:0]  rem;
    logic [ADDR_BITS-1:0] split_start;
    logic [END_W-1:0]   base;
    logic [SUM_W-1:0]   app_s, app_e;
    logic               app_ok;
    logic [END_W-1:0]   ld_e;
    logic               ld_ok;
    logic [END_W-1:0]   prev_end;
    logic               mcond;
    logic [SIZE_W-1:0]  merged;

    logic               tbl_wr, tbl_split, tbl_merge;
    logic [IDX_W-1:0]   w_idx;
    entry_t             w_ent;
    logic [CNT_W-1:0]   sp_idx;
    entry_t             sp_keep, sp_new;
    logic [CNT_W-1:0]   mg_idx;
    logic [SIZE_W-1:0]  mg_size;

    // Select the single table read address
    assign mi_p1  = {1'b0, mi_reg} + CNT_W'(1);
    assign pos_p1 = {1'b0, scan_pos_reg} + CNT_W'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_SCAN:   rd_idx = scan_pos_reg;
            RD_FOUND:  rd_idx = found_idx_reg;
            RD_LAST:   rd_idx = IDX_W'(count_reg - CNT_W'(1));
            RD_FREE:   rd_idx = IDX_W'(req_reg.free_index);
            RD_ZERO:   rd_idx = '0;
            RD_MNEXT:  rd_idx = IDX_W'(mi_p1);
            RD_TARGET: rd_idx = target_reg;
            default:   rd_idx = '0;
        endcase
    end

    assign rd     = ent_reg[rd_idx];
    assign rd_end = {1'b0, rd.start} + {1'b0, rd.size};
    assign full   = (count_reg >= CNT_MAX);

    // Search compare
    assign hit    = !rd.used && (rd.size >= req_reg.req_size);
    assign better = !found_reg ||
                    ((fit_policy == POL_BEST) && (rd.size < best_size_reg)) ||
                    ((fit_policy == POL_WORST) && (rd.size > best_size_reg));

    // Exact fit or split of the found block
    assign exact       = (rd.size == req_reg.req_size);
    assign rem         = rd.size - req_reg.req_size;
    assign split_start = rd.start + ADDR_BITS'(rem);

    // Append past the last partition
    assign base   = (count_reg == '0) ? '0 : rd_end;
    assign app_s  = SUM_W'(base) + SUM_W'(append_gap);
    assign app_e  = app_s + SUM_W'(req_reg.req_size);
    assign app_ok = !full && (app_e <= ADDR_LIMIT);

    // Load at the table end
    assign ld_e  = {1'b0, req_reg.load_start} + {1'b0, req_reg.req_size};
    assign ld_ok = (req_reg.req_size != '0) && !full && (ld_e <= END_W'(ADDR_LIMIT)) &&
                   !((count_reg != '0) && ({1'b0, req_reg.load_start} < rd_end));

    // Merge test between the held entry and the next one
    assign prev_end = {1'b0, prev_reg.start} + {1'b0, prev_reg.size};
    assign mcond    = !prev_reg.used && !rd.used && (prev_end == {1'b0, rd.start});
    assign merged   = prev_reg.size + rd.size;

    // Decode table writes
    always_comb
    begin
        tbl_wr    = 1'b0;
        tbl_split = 1'b0;
        tbl_merge = 1'b0;
        w_idx     = rd_idx;
        w_ent     = rd;
        sp_idx    = {1'b0, found_idx_reg};
        sp_keep   = '{start: rd.start, size: rem, used: 1'b0};
        sp_new    = '{start: split_start, size: req_reg.req_size, used: 1'b1};
        mg_idx    = {1'b0, mi_reg};
        mg_size   = merged;
        if (cmd.fit && exact)
        begin
            tbl_wr = 1'b1;
            w_idx  = found_idx_reg;
            w_ent  = '{start: rd.start, size: rd.size, used: 1'b1};
        end
        if (cmd.fit && !exact && !full)
        begin
            tbl_split = 1'b1;
        end
        if (cmd.append && app_ok)
        begin
            tbl_wr = 1'b1;
            w_idx  = IDX_W'(count_reg);
            w_ent  = '{start: app_s[ADDR_BITS-1:0], size: req_reg.req_size, used: 1'b1};
        end
        if (cmd.load && ld_ok)
        begin
            tbl_wr = 1'b1;
            w_idx  = IDX_W'(count_reg);
            w_ent  = '{start: req_reg.load_start, size: req_reg.req_size,
                       used: req_reg.load_used};
        end
        if (cmd.free_clr)
        begin
            tbl_wr = 1'b1;
            w_idx  = IDX_W'(req_reg.free_index);
            w_ent  = '{start: rd.start, size: rd.size, used: 1'b0};
        end
        if (cmd.merge_step && mcond)
        begin
            tbl_merge = 1'b1;
        end
    end

    // Per-entry update: write, shift up on split, shift down on merge
    for (genvar gk = 0; gk < MAX_PARTS; gk++)
    begin : g_ent
        localparam logic [CNT_W-1:0] K = CNT_W'(gk);
        entry_t up_src, dn_src;

        if (gk > 0)
        begin : g_up
            assign up_src = ent_reg[gk-1];
        end
        else
        begin : g_up0
            assign up_src = ent_reg[gk];
        end

        if (gk < MAX_PARTS - 1)
        begin : g_dn
            assign dn_src = ent_reg[gk+1];
        end
        else
        begin : g_dnl
            assign dn_src = ent_reg[gk];
        end

        always_comb
        begin
            ent_next[gk] = ent_reg[gk];
            if (tbl_wr && (w_idx == IDX_W'(gk)))
            begin
                ent_next[gk] = w_ent;
            end
            if (tbl_split)
            begin
                if (sp_idx == K)
                begin
                    ent_next[gk] = sp_keep;
                end
                else if (sp_idx + CNT_W'(1) == K)
                begin
                    ent_next[gk] = sp_new;
                end
                else if (K > sp_idx + CNT_W'(1))
                begin
                    ent_next[gk] = up_src;
                end
            end
            if (tbl_merge)
            begin
                if (mg_idx == K)
                begin
                    ent_next[gk] = '{start: ent_reg[gk].start, size: mg_size,
                                     used: ent_reg[gk].used};
                end
                else if (K > mg_idx)
                begin
                    ent_next[gk] = dn_src;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            ent_reg[gk] <= ent_next[gk];
        end
    end

    // Count, rover and search flag
    always_comb
    begin
        count_next = count_reg;
        rover_next = rover_reg;
        found_next = found_reg;
        if (tbl_split || (cmd.append && app_ok) || (cmd.load && ld_ok))
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (tbl_merge)
        begin
            count_next = count_reg - CNT_W'(1);
            if (rover_reg > mi_reg)
            begin
                rover_next = rover_reg - IDX_W'(1);
            end
        end
        if (fit_policy == POL_NEXT)
        begin
            if (cmd.fit && exact)
            begin
                rover_next = (({1'b0, found_idx_reg} + CNT_W'(1)) < count_reg) ?
                             found_idx_reg + IDX_W'(1) : '0;
            end
            if (tbl_split)
            begin
                rover_next = found_idx_reg;
            end
            if (cmd.append && app_ok)
            begin
                rover_next = '0;
            end
        end
        if (cmd.scan_init)
        begin
            found_next = 1'b0;
        end
        if (cmd.scan_step && hit && better)
        begin
            found_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rover_reg <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rover_reg <= rover_next;
            found_reg <= found_next;
        end
    end

    // Result of the current item
    always_comb
    begin
        res_load = 1'b1;
        res_next = '{status: STS_NOROOM, part_index: '0, start_addr: '0, end_addr: '0};
        if (cmd.badidx)
        begin
            res_next.status     = STS_BADIDX;
            res_next.part_index = req_reg.free_index;
        end
        else if (cmd.fit)
        begin
            if (exact)
            begin
                res_next = '{status: STS_EXACT, part_index: PIDX_W'(found_idx_reg),
                             start_addr: rd.start, end_addr: rd_end[15:0]};
            end
            else if (!full)
            begin
                res_next = '{status: STS_SPLIT,
                             part_index: PIDX_W'(found_idx_reg + IDX_W'(1)),
                             start_addr: split_start, end_addr: rd_end[15:0]};
            end
        end
        else if (cmd.append)
        begin
            if (app_ok)
            begin
                res_next = '{status: STS_APPENDED, part_index: PIDX_W'(count_reg),
                             start_addr: app_s[15:0], end_addr: app_e[15:0]};
            end
        end
        else if (cmd.load)
        begin
            if (ld_ok)
            begin
                res_next = '{status: STS_LOADED, part_index: PIDX_W'(count_reg),
                             start_addr: req_reg.load_start, end_addr: ld_e[15:0]};
            end
        end
        else if (cmd.free_rpt)
        begin
            res_next = '{status: STS_FREED, part_index: PIDX_W'(target_reg),
                         start_addr: rd.start, end_addr: rd_end[15:0]};
        end
        else if (!cmd.reject)
        begin
            res_load = 1'b0;
        end
    end

    // Payload and scratch registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg <= req;
        end
        if (cmd.scan_init)
        begin
            scan_pos_reg <= ((fit_policy == POL_NEXT) && ({1'b0, rover_reg} < count_reg)) ?
                            rover_reg : '0;
            scan_cnt_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            scan_pos_reg <= (pos_p1 >= count_reg) ? '0 : IDX_W'(pos_p1);
            if (hit && better)
            begin
                found_idx_reg <= scan_pos_reg;
                best_size_reg <= rd.size;
            end
        end
        if (cmd.merge_init)
        begin
            prev_reg   <= rd;
            mi_reg     <= '0;
            target_reg <= IDX_W'(req_reg.free_index);
        end
        if (cmd.merge_step)
        begin
            if (mcond)
            begin
                prev_reg.size <= merged;
                if (target_reg > mi_reg)
                begin
                    target_reg <= target_reg - IDX_W'(1);
                end
            end
            else
            begin
                prev_reg <= rd;
                mi_reg   <= IDX_W'(mi_p1);
            end
        end
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if (cmd.out_load)
        begin
            rsp_reg <= res_reg;
        end
    end

    // Status toward the controller
    assign stat.op         = req_reg.operation;
    assign stat.size_zero  = (req_reg.req_size == '0);
    assign stat.idx_bad    = ({1'b0, req_reg.free_index} >= count_reg);
    assign stat.count_zero = (count_reg == '0);
    assign stat.scan_last  = (hit && ((fit_policy == POL_FIRST) || (fit_policy == POL_NEXT))) ||
                             ((scan_cnt_reg + CNT_W'(1)) >= count_reg);
    assign stat.found      = found_reg;
    assign stat.merge_done = (mi_p1 >= count_reg);

    assign rsp = rsp_reg;

endmodule

// ===== rtl/vpa_ctrl.sv =====
// Controller of the partition allocator: sequences scan, fit, append,
// free and merge steps and owns the handshakes. Depends on vpa_pkg.
module vpa_ctrl
    import vpa_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_stall,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DISPATCH   = 4'd1;
    localparam logic [3:0] S_SCAN       = 4'd2;
    localparam logic [3:0] S_FIT        = 4'd3;
    localparam logic [3:0] S_APPEND     = 4'd4;
    localparam logic [3:0] S_MERGE_INIT = 4'd5;
    localparam logic [3:0] S_MERGE      = 4'd6;
    localparam logic [3:0] S_FREE_RPT   = 4'd7;
    localparam logic [3:0] S_EMIT       = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (stat.op)
                    OP_ALLOC:
                    begin
                        if (stat.size_zero)
                        begin
                            cmd.reject = 1'b1;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = stat.count_zero ? S_FIT : S_SCAN;
                        end
                    end
                    OP_FREE:
                    begin
                        if (stat.idx_bad)
                        begin
                            cmd.badidx = 1'b1;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cmd.rd_sel   = RD_FREE;
                            cmd.free_clr = 1'b1;
                            state_next   = S_MERGE_INIT;
                        end
                    end
                    OP_LOAD:
                    begin
                        cmd.rd_sel = RD_LAST;
                        cmd.load   = 1'b1;
                        state_next = S_EMIT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.rd_sel    = RD_SCAN;
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = S_FIT;
                end
            end
            S_FIT:
            begin
                cmd.rd_sel = RD_FOUND;
                if (stat.found)
                begin
                    cmd.fit    = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end
            S_APPEND:
            begin
                cmd.rd_sel = RD_LAST;
                cmd.append = 1'b1;
                state_next = S_EMIT;
            end
            S_MERGE_INIT:
            begin
                cmd.rd_sel     = RD_ZERO;
                cmd.merge_init = 1'b1;
                state_next     = S_MERGE;
            end
            S_MERGE:
            begin
                cmd.rd_sel = RD_MNEXT;
                if (stat.merge_done)
                begin
                    state_next = S_FREE_RPT;
                end
                else
                begin
                    cmd.merge_step = 1'b1;
                end
            end
            S_FREE_RPT:
            begin
                cmd.rd_sel   = RD_TARGET;
                cmd.free_rpt = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the output beat until taken
    assign out_valid_next = cmd.out_load ? 1'b1 : (out_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    // Never overwrite a result beat that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !rsp_stall))
        else $error("result beat overwritten while stalled");

    // An accepted item blocks further input on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("input not stalled after accept");

    // A new result beat comes only from the emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load) |-> (state_reg == S_EMIT))
        else $error("result loaded outside emit");

    // A scan step is issued only in the scan state and on a non-empty table
    a_scan_cmds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (state_reg == S_SCAN && !stat.count_zero))
        else $error("scan step on empty table");
`endif

endmodule

// ===== dv/tb_variable_partition_allocator.sv =====
// Self-checking testbench for the variable partition allocator: directed table
// plus random traffic, checked beat by beat against a built-in table predictor.
// Depends on vpa_pkg and the variable_partition_allocator RTL.
`timescale 1ns / 1ps

module tb_variable_partition_allocator;
    import vpa_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    req_t              req;
    logic              rsp_valid;
    logic              rsp_stall;
    rsp_t              rsp;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    variable_partition_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    localparam int GAP_IDLE   = 0;
    localparam int GAP_SEND   = 1;
    localparam int GAP_STALL  = 2;
    localparam int GAP_BOTH   = 3;
    localparam int HOLD_CYCLES = 400;
    localparam logic [APB_AW-1:0] ADDR_POLICY = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_GAP    = 3'd4;
    localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;

    // Predicted partition table
    logic [16:0]      tbl_start [MAX_PARTS];
    logic [16:0]      tbl_size  [MAX_PARTS];
    logic             tbl_used  [MAX_PARTS];
    int               tbl_count;
    int               rover;
    logic [POL_W-1:0] policy;
    logic [GAP_W-1:0] gap;

    rsp_t expected_rsp [$];
    int   mismatches;
    int   row_errors;
    int   rsp_seen;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off;
    logic hold_go;
    int   n_split, n_append, n_merge, n_noroom;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic rsp_t make_rsp(logic [2:0] st, int idx, logic [16:0] s, logic [16:0] e);
        rsp_t r;
        r.status     = st;
        r.part_index = idx[4:0];
        r.start_addr = s[15:0];
        r.end_addr   = e[15:0];
        return r;
    endfunction

    function automatic rsp_t entry_rsp(logic [2:0] st, int i);
        return make_rsp(st, i, tbl_start[i], tbl_start[i] + tbl_size[i]);
    endfunction

    function automatic void shift_up(int i);
        for (int k = tbl_count; k > i; k--) begin
            tbl_start[k] = tbl_start[k-1];
            tbl_size[k]  = tbl_size[k-1];
            tbl_used[k]  = tbl_used[k-1];
        end
        tbl_count++;
    endfunction

    function automatic int search_fit(logic [16:0] sz);
        int best;
        int j;
        best = -1;
        if (policy == POL_NEXT) begin
            for (int i = 0; i < tbl_count; i++) begin
                j = ((rover < tbl_count) ? rover : 0) + i;
                if (j >= tbl_count) j -= tbl_count;
                if (!tbl_used[j] && tbl_size[j] >= sz) return j;
            end
            return -1;
        end
        for (int i = 0; i < tbl_count; i++) begin
            if (tbl_used[i] || tbl_size[i] < sz) continue;
            if (policy == POL_FIRST) return i;
            if (best < 0 || (policy == POL_BEST && tbl_size[i] < tbl_size[best]) ||
                (policy == POL_WORST && tbl_size[i] > tbl_size[best]))
                best = i;
        end
        return best;
    endfunction

    // Work out the result of one request and advance the predicted table
    function automatic bit predict_partition(req_t r, output rsp_t res);
        logic [16:0] sz;
        logic [16:0] base;
        rsp_t        reject;
        int          f;
        int          target;
        int          i;
        sz     = {1'b0, r.req_size};
        reject = make_rsp(STS_NOROOM, 0, 17'd0, 17'd0);
        res    = reject;
        case (r.operation)
            OP_ALLOC: begin
                if (sz == 0) return 1;
                f = search_fit(sz);
                if (f >= 0) begin
                    if (tbl_size[f] == sz) begin
                        tbl_used[f] = 1'b1;
                        if (policy == POL_NEXT) rover = (f + 1 < tbl_count) ? f + 1 : 0;
                        res = entry_rsp(STS_EXACT, f);
                        return 1;
                    end
                    if (tbl_count >= MAX_PARTS) return 1;
                    tbl_size[f] = tbl_size[f] - sz;
                    shift_up(f + 1);
                    tbl_start[f+1] = tbl_start[f] + tbl_size[f];
                    tbl_size[f+1]  = sz;
                    tbl_used[f+1]  = 1'b1;
                    if (policy == POL_NEXT) rover = f;
                    res = entry_rsp(STS_SPLIT, f + 1);
                    return 1;
                end
                if (tbl_count >= MAX_PARTS) return 1;
                base = (tbl_count > 0) ?
                       tbl_start[tbl_count-1] + tbl_size[tbl_count-1] : 17'd0;
                base = base + gap;
                if ({1'b0, base} + sz > 18'hFFFF) return 1;
                shift_up(tbl_count);
                tbl_start[tbl_count-1] = base;
                tbl_size[tbl_count-1]  = sz;
                tbl_used[tbl_count-1]  = 1'b1;
                if (policy == POL_NEXT) rover = 0;
                res = entry_rsp(STS_APPENDED, tbl_count - 1);
                return 1;
            end
            OP_FREE: begin
                if (r.free_index >= tbl_count) begin
                    res = make_rsp(STS_BADIDX, r.free_index, 17'd0, 17'd0);
                    return 1;
                end
                target = r.free_index;
                tbl_used[target] = 1'b0;
                i = 0;
                while (i + 1 < tbl_count) begin
                    if (!tbl_used[i] && !tbl_used[i+1] &&
                        tbl_start[i] + tbl_size[i] == tbl_start[i+1]) begin
                        tbl_size[i] = tbl_size[i] + tbl_size[i+1];
                        for (int k = i + 1; k + 1 < tbl_count; k++) begin
                            tbl_start[k] = tbl_start[k+1];
                            tbl_size[k]  = tbl_size[k+1];
                            tbl_used[k]  = tbl_used[k+1];
                        end
                        tbl_count--;
                        if (target > i) target--;
                        if (rover > i) rover--;
                    end else begin
                        i++;
                    end
                end
                res = entry_rsp(STS_FREED, target);
                return 1;
            end
            OP_LOAD: begin
                if (sz == 0 || tbl_count >= MAX_PARTS ||
                    {2'b0, r.load_start} + sz > 18'hFFFF) return 1;
                if (tbl_count > 0 &&
                    r.load_start < tbl_start[tbl_count-1] + tbl_size[tbl_count-1]) return 1;
                shift_up(tbl_count);
                tbl_start[tbl_count-1] = r.load_start;
                tbl_size[tbl_count-1]  = sz;
                tbl_used[tbl_count-1]  = r.load_used;
                res = entry_rsp(STS_LOADED, tbl_count - 1);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic req_t make_req(logic [1:0] op, logic [15:0] sz, logic [15:0] ls,
                                      logic lu, logic [4:0] fi);
        req_t r;
        r.operation  = op;
        r.req_size   = sz;
        r.load_start = ls;
        r.load_used  = lu;
        r.free_index = fi;
        return r;
    endfunction

    // Send one beat; queue its expectation once accepted
    task automatic send_beat(req_t r, bit has_fixed, rsp_t fixed);
        rsp_t pred;
        bit   has_rsp;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        has_rsp = predict_partition(r, pred);
        if (has_rsp) begin
            if (has_fixed && pred != fixed) begin
                row_errors++;
                $display("directed row disagrees: table %h predictor %h", fixed, pred);
            end
            expected_rsp.push_back(pred);
            case (pred.status)
                STS_SPLIT:    n_split++;
                STS_APPENDED: n_append++;
                STS_NOROOM:   n_noroom++;
                default: ;
            endcase
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [APB_AW-1:0] a, logic [APB_DW-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (a == ADDR_POLICY) policy = d[POL_W-1:0];
        else gap = d[GAP_W-1:0];
        @(posedge clk);
    endtask

    // Receiver: random stall, long hold-off on request
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
            hold_off  <= 0;
        end else if (hold_go) begin
            rsp_stall <= 1'b1;
            hold_off  <= HOLD_CYCLES;
        end else if (hold_off > 0) begin
            rsp_stall <= 1'b1;
            hold_off  <= hold_off - 1;
        end else begin
            rsp_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge clk) begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            rsp_seen++;
            if (expected_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", rsp);
            end else begin
                want = expected_rsp.pop_front();
                if (want != rsp) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d idx=%0d s=%h e=%h got st=%0d idx=%0d s=%h e=%h",
                                 want.status, want.part_index, want.start_addr, want.end_addr,
                                 rsp.status, rsp.part_index, rsp.start_addr, rsp.end_addr);
                end
            end
        end
    end

    initial begin
        #50ms;
        $display("[variable_partition_allocator] ERROR");
        $finish;
    end

    // Directed table
    typedef struct {
        req_t r;
        bit   fixed;
        rsp_t want;
    } row_t;

    initial begin
        row_t        rows [$];
        rsp_t        dummy;
        int          phase;
        int          pick;
        logic [15:0] sz;
        logic [15:0] ls;
        rsp_t        nr;
        nr = make_rsp(STS_NOROOM, 0, 17'd0, 17'd0);
        rst_n = 1'b0; req_valid = 1'b0; req = '0; hold_go = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        tbl_count = 0; rover = 0; policy = POL_FIRST; gap = '0;
        mismatches = 0; row_errors = 0; rsp_seen = 0; send_idle_pct = 0; recv_stall_pct = 0;
        n_split = 0; n_append = 0; n_merge = 0; n_noroom = 0;
        dummy = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rejects, bad index, loads, each fit, merges, extremes
        rows.push_back('{make_req(OP_FREE, 16'd5, 16'd0, 1'b0, 5'd31), 1,
                         make_rsp(STS_BADIDX, 31, 17'd0, 17'd0)});
        rows.push_back('{make_req(OP_ALLOC, 16'd0, 16'hFFFF, 1'b1, 5'd0), 1, nr});
        rows.push_back('{make_req(OP_LOAD, 16'd0, 16'd0, 1'b0, 5'd0), 1, nr});
        rows.push_back('{make_req(OP_LOAD, 16'hFFFF, 16'd1, 1'b0, 5'd0), 1, nr});
        rows.push_back('{make_req(OP_LOAD, 16'd100, 16'd0, 1'b0, 5'd0), 1,
                         make_rsp(STS_LOADED, 0, 17'd0, 17'd100)});
        rows.push_back('{make_req(OP_LOAD, 16'd50, 16'd50, 1'b0, 5'd0), 1, nr});
        rows.push_back('{make_req(OP_LOAD, 16'd40, 16'd100, 1'b1, 5'd0), 0, dummy});
        rows.push_back('{make_req(OP_LOAD, 16'd300, 16'd200, 1'b0, 5'd0), 0, dummy});
        rows.push_back('{make_req(OP_LOAD, 16'd100, 16'd600, 1'b0, 5'd0), 0, dummy});
        rows.push_back('{make_req(OP_ALLOC, 16'd100, 16'd0, 1'b0, 5'd0), 0, dummy});
        rows.push_back('{make_req(OP_ALLOC, 16'd30, 16'd0, 1'b0, 5'd0), 0, dummy});
        rows.push_back('{make_req(OP_ALLOC, 16'd5000, 16'd0, 1'b0, 5'd0), 0, dummy});
        rows.push_back('{make_req(OP_ALLOC, 16'hFFFF, 16'd0, 1'b0, 5'd0), 1, nr});
        rows.push_back('{make_req(OP_UNUSED, 16'd1, 16'd0, 1'b0, 5'd0), 0, dummy});
        rows.push_back('{make_req(OP_FREE, 16'd0, 16'd0, 1'b0, 5'd1), 0, dummy});
        rows.push_back('{make_req(OP_FREE, 16'd0, 16'd0, 1'b0, 5'd0), 0, dummy});
        rows.push_back('{make_req(OP_FREE, 16'd0, 16'd0, 1'b0, 5'd0), 0, dummy});
        rows.push_back('{make_req(OP_LOAD, 16'd1, 16'hFFFE, 1'b1, 5'd0), 0, dummy});
        foreach (rows[k]) send_beat(rows[k].r, rows[k].fixed, rows[k].want);
        drain();

        // Random phases over every policy and gap extreme, varying idle mix
        for (phase = 0; phase < 16; phase++) begin
            write_reg(ADDR_POLICY, phase % 4);
            write_reg(ADDR_GAP, (phase < 4) ? 0 : (phase < 8) ? 255 : $urandom_range(255));
            case ((phase / 2) % 4)
                GAP_IDLE:  begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                GAP_SEND:  begin send_idle_pct = 72; recv_stall_pct = 0;  end
                GAP_STALL: begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default:   begin send_idle_pct = 8;  recv_stall_pct = 8;  end
            endcase
            if (phase == 5) begin
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            // Mostly well-formed: loads while small, then allocate/free churn
            for (int n = 0; n < 70; n++) begin
                pick = $urandom_range(99);
                sz = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 600));
                if ($urandom_range(19) == 0) sz = 0;
                if (pick < 15 || tbl_count < 3) begin
                    ls = (tbl_count > 0) ?
                         16'(tbl_start[tbl_count-1] + tbl_size[tbl_count-1] + $urandom_range(0, 3))
                         : 16'($urandom_range(0, 200));
                    if ($urandom_range(9) == 0) ls = 16'($urandom);
                    send_beat(make_req(OP_LOAD, sz, ls, 1'($urandom), 5'($urandom)), 0, dummy);
                end else if (pick < 55) begin
                    send_beat(make_req(OP_ALLOC, sz, 16'($urandom), 1'($urandom),
                                       5'($urandom)), 0, dummy);
                end else if (pick < 97) begin
                    send_beat(make_req(OP_FREE, 16'($urandom), 16'($urandom), 1'($urandom),
                              5'($urandom_range(0, (tbl_count > 0) ? tbl_count - 1 : 0))),
                              0, dummy);
                    n_merge++;
                end else begin
                    send_beat(make_req(2'($urandom_range(1, 3)), 16'($urandom), 16'($urandom),
                                       1'($urandom), 5'($urandom)), 0, dummy);
                end
            end
            drain();
        end

        $display("covered %0d results over 4 policies and gap extremes: %0d splits, %0d appends,",
                 rsp_seen, n_split, n_append);
        $display("%0d frees, %0d rejects, with sender/receiver idling and a long output hold-off",
                 n_merge, n_noroom);
        if (mismatches == 0 && row_errors == 0 && expected_rsp.size() == 0)
            $display("[variable_partition_allocator] OK");
        else
            $display("[variable_partition_allocator] ERROR");
        $finish;
    end
endmodule

// ===== variable_partition_allocator.f =====
rtl/vpa_pkg.sv
rtl/vpa_datapath.sv
rtl/vpa_ctrl.sv
rtl/variable_partition_allocator.sv
dv/tb_variable_partition_allocator.sv
